// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL files that check their own behavior
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset
`define SCE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition never holds outside reset
`define SCE_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SCE_ASSERT(label, clk, rst, prop, msg)
`define SCE_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ----- rtl/core/sce_pkg.sv -----
// Types, codes and constants of the stack calculator engine
package sce_pkg;

   localparam int DEFAULT_STACK_DEPTH = 64;

   // Request codes
   localparam logic [2:0] REQ_PUSH = 3'd0;
   localparam logic [2:0] REQ_POP  = 3'd1;
   localparam logic [2:0] REQ_PEEK = 3'd2;
   localparam logic [2:0] REQ_ADD  = 3'd3;
   localparam logic [2:0] REQ_SUB  = 3'd4;
   localparam logic [2:0] REQ_MUL  = 3'd5;
   localparam logic [2:0] REQ_DIV  = 3'd6;

   // Status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_UNDER = 3'd2;
   localparam logic [2:0] ST_OVER  = 3'd3;
   localparam logic [2:0] ST_DIVZ  = 3'd4;

   // Iteration counts of the shared multiply and divide steps
   localparam logic [6:0] MUL_STEPS = 7'd5;
   localparam logic [6:0] DIV_STEPS = 7'd96;
   localparam logic [6:0] NUM_BITS  = 7'd64;

   localparam logic [63:0] QMAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] QMIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [63:0] operand_value;
   } sce_req_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic [2:0]         status;
      logic [6:0]         entry_count;
   } sce_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_RD1,
      S_RD2,
      S_EXEC,
      S_DONE
   } sce_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       accept;
      logic       push;
      logic       fail;
      logic [2:0] fail_code;
      logic       rd_next;
      logic       take_top;
      logic       cap_x1;
      logic       load_ops;
      logic       step;
      logic       commit;
      logic       emit;
   } sce_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_push;
      logic is_pop_peek;
      logic is_arith;
      logic depth_zero;
      logic depth_lt2;
      logic depth_full;
      logic op_done;
      logic out_free;
   } sce_stat_type;

endpackage

// ----- rtl/core/sce_ctrl.sv -----
// Request sequencer of the stack calculator engine
module sce_ctrl
   import sce_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sce_stat_type stat,
   output sce_cmd_type  cmd
);

   sce_state_type state_ff, state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decide next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            if (stat.is_push) begin
               if (stat.depth_full) begin
                  cmd.fail      = 1'b1;
                  cmd.fail_code = ST_OVER;
               end else begin
                  cmd.push = 1'b1;
               end
            end else if (stat.is_pop_peek) begin
               if (stat.depth_zero) begin
                  cmd.fail      = 1'b1;
                  cmd.fail_code = ST_EMPTY;
               end else begin
                  state_in = S_RD1;
               end
            end else if (stat.is_arith) begin
               if (stat.depth_lt2) begin
                  cmd.fail      = 1'b1;
                  cmd.fail_code = ST_UNDER;
               end else begin
                  state_in = S_RD1;
               end
            end else begin
               cmd.fail      = 1'b1;
               cmd.fail_code = ST_OK;
            end
         end
         S_RD1: begin
            if (stat.is_arith) begin
               cmd.cap_x1  = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = S_RD2;
            end else begin
               cmd.take_top = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_RD2: begin
            cmd.load_ops = 1'b1;
            state_in     = S_EXEC;
         end
         S_EXEC: begin
            if (stat.op_done) begin
               cmd.commit = 1'b1;
               state_in   = S_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/sce_dp.sv -----
// Stack memory, arithmetic units and result register of the stack calculator engine
module sce_dp
   import sce_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  sce_req_type  req_data,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output sce_rsp_type  rsp_data,
   input  sce_cmd_type  cmd,
   output sce_stat_type stat,
   output logic         depth_over
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);

   logic [63:0]   stack_mem [STACK_DEPTH];
   logic [63:0]   rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          wr_en;
   logic [63:0]   wr_data;

   sce_req_type   req_ff;
   logic [DW-1:0] depth_ff, depth_in;
   logic [DW-1:0] depth_m1, depth_m2;
   logic [63:0]   x1_ff, x2_ff;
   logic [63:0]   ma_ff, mb_ff;
   logic          neg_ff;
   logic [6:0]    cnt_ff;
   logic [127:0]  acc_ff;
   logic [63:0]   pp_ff;
   logic [1:0]    sh_ff;
   logic [63:0]   num_ff;
   logic [63:0]   rem_ff;
   logic [63:0]   q_ff;
   logic          big_ff;
   logic [63:0]   res_ff;
   logic [2:0]    st_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   sce_rsp_type   rsp_data_ff;

   logic [63:0]   x2_mag, x1_mag;
   logic [31:0]   a_half, b_half;
   logic [127:0]  acc_add;
   logic [64:0]   rem_sh;
   logic          rem_ge;
   logic [63:0]   sum, diff;
   logic          add_ovf, sub_ovf;
   logic [64:0]   mul_pk, div_pk;
   logic [63:0]   calc_res;
   logic [2:0]    calc_st;

   // Magnitude of a two's complement value
   function automatic logic [63:0] mag64(input logic [63:0] v);
      mag64 = v[63] ? (64'd0 - v) : v;
   endfunction

   // Saturate sign and magnitude to Q32.32; bit 64 flags saturation
   function automatic logic [64:0] pack_q(input logic neg, input logic big,
                                          input logic [63:0] mag);
      if (neg) begin
         if (big || (mag > QMIN)) pack_q = {1'b1, QMIN};
         else pack_q = {1'b0, 64'd0 - mag};
      end else begin
         if (big || (mag > QMAX)) pack_q = {1'b1, QMAX};
         else pack_q = {1'b0, mag};
      end
   endfunction

   assign depth_m1 = depth_ff - DW'(1);
   assign depth_m2 = depth_ff - DW'(2);
   assign rd_addr  = cmd.rd_next ? depth_m2[AW-1:0] : depth_m1[AW-1:0];

   // Classify the held request against the stack depth
   always_comb begin
      stat.is_push     = (req_ff.req_type == REQ_PUSH);
      stat.is_pop_peek = (req_ff.req_type == REQ_POP) || (req_ff.req_type == REQ_PEEK);
      stat.is_arith    = (req_ff.req_type == REQ_ADD) || (req_ff.req_type == REQ_SUB) ||
                         (req_ff.req_type == REQ_MUL) || (req_ff.req_type == REQ_DIV);
      stat.depth_zero  = (depth_ff == '0);
      stat.depth_lt2   = (depth_ff < DW'(2));
      stat.depth_full  = (depth_ff >= DEPTH_MAX);
      stat.out_free    = !rsp_valid_ff || !rsp_stall;
      case (req_ff.req_type)
         REQ_MUL: stat.op_done = (cnt_ff == MUL_STEPS);
         REQ_DIV: stat.op_done = (x1_ff == 64'd0) || (cnt_ff == DIV_STEPS);
         default: stat.op_done = 1'b1;
      endcase
   end

   assign depth_over = (depth_ff > DEPTH_MAX);

   // Multiply: pick the 32-bit halves for this partial product
   assign a_half  = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign b_half  = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
   assign acc_add = {64'd0, pp_ff} << {sh_ff, 5'd0};

   // Divide: one restoring step
   assign rem_sh = {rem_ff, (cnt_ff < NUM_BITS) ? num_ff[63] : 1'b0};
   assign rem_ge = (rem_sh >= {1'b0, mb_ff});

   // Final result of the operation
   assign x2_mag  = mag64(rd_data_ff);
   assign x1_mag  = mag64(x1_ff);
   assign sum     = x2_ff + x1_ff;
   assign diff    = x2_ff - x1_ff;
   assign add_ovf = (x2_ff[63] == x1_ff[63]) && (sum[63] != x2_ff[63]);
   assign sub_ovf = (x2_ff[63] != x1_ff[63]) && (diff[63] != x2_ff[63]);
   assign mul_pk  = pack_q(neg_ff, acc_ff[127:96] != 32'd0, acc_ff[95:32]);
   assign div_pk  = pack_q(neg_ff, big_ff, q_ff);

   always_comb begin
      calc_res = 64'd0;
      calc_st  = ST_OK;
      case (req_ff.req_type)
         REQ_ADD: begin
            calc_res = add_ovf ? (x2_ff[63] ? QMIN : QMAX) : sum;
            calc_st  = add_ovf ? ST_OVER : ST_OK;
         end
         REQ_SUB: begin
            calc_res = sub_ovf ? (x2_ff[63] ? QMIN : QMAX) : diff;
            calc_st  = sub_ovf ? ST_OVER : ST_OK;
         end
         REQ_MUL: begin
            calc_res = mul_pk[63:0];
            calc_st  = mul_pk[64] ? ST_OVER : ST_OK;
         end
         default: begin
            if (x1_ff == 64'd0) begin
               calc_res = (x2_ff == 64'd0) ? 64'd0 : (x2_ff[63] ? QMIN : QMAX);
               calc_st  = ST_DIVZ;
            end else begin
               calc_res = div_pk[63:0];
               calc_st  = div_pk[64] ? ST_OVER : ST_OK;
            end
         end
      endcase
   end

   // Select the stack write
   assign wr_en   = cmd.push || cmd.commit;
   assign wr_addr = cmd.push ? depth_ff[AW-1:0] : depth_m2[AW-1:0];
   assign wr_data = cmd.push ? req_ff.operand_value : calc_res;

   // Write and read the stack memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   // Advance the depth count
   always_comb begin
      depth_in = depth_ff;
      if (cmd.push) begin
         depth_in = depth_ff + DW'(1);
      end else if (cmd.commit || (cmd.take_top && req_ff.req_type == REQ_POP)) begin
         depth_in = depth_m1;
      end
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request, operands and step the arithmetic
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.cap_x1) begin
         x1_ff <= rd_data_ff;
      end
      if (cmd.load_ops) begin
         x2_ff  <= rd_data_ff;
         ma_ff  <= x2_mag;
         mb_ff  <= x1_mag;
         num_ff <= x2_mag;
         neg_ff <= rd_data_ff[63] ^ x1_ff[63];
         acc_ff <= (rd_data_ff[63] ^ x1_ff[63]) ? 128'h0000_0000_FFFF_FFFF : 128'd0;
         pp_ff  <= 64'd0;
         sh_ff  <= 2'd0;
         rem_ff <= 64'd0;
         q_ff   <= 64'd0;
         big_ff <= 1'b0;
         cnt_ff <= 7'd0;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff + 7'd1;
         if (req_ff.req_type == REQ_MUL) begin
            acc_ff <= acc_ff + acc_add;
            pp_ff  <= a_half * b_half;
            sh_ff  <= {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
         end else begin
            num_ff <= {num_ff[62:0], 1'b0};
            rem_ff <= rem_ge ? (rem_sh[63:0] - mb_ff) : rem_sh[63:0];
            big_ff <= big_ff || q_ff[63];
            q_ff   <= {q_ff[62:0], rem_ge};
         end
      end
      if (cmd.fail) begin
         res_ff <= 64'd0;
         st_ff  <= cmd.fail_code;
      end else if (cmd.push) begin
         res_ff <= 64'd0;
         st_ff  <= ST_OK;
      end else if (cmd.take_top) begin
         res_ff <= rd_data_ff;
         st_ff  <= ST_OK;
      end else if (cmd.commit) begin
         res_ff <= calc_res;
         st_ff  <= calc_st;
      end
      if (cmd.emit) begin
         rsp_data_ff.result_value <= res_ff;
         rsp_data_ff.status       <= st_ff;
         rsp_data_ff.entry_count  <= 7'(depth_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/core/stack_calculator_engine.sv -----
// Top level of the stack calculator engine
//
// An RPN calculator stack of signed Q32.32 values. Each request on the req_
// channel (push, pop, peek, add, subtract, multiply, divide) gives exactly
// one response on the rsp_ channel with the value, a status code and the
// entry count after the request. Both channels move data when valid is high
// and stall is low. One request is worked at a time; req_stall stays high
// from acceptance until the response is loaded into the output register.
// The divide uses a restoring divider that produces one quotient bit per
// cycle; the multiply uses one 32x32 partial product per cycle.
// The stack is one memory with one write and one registered read port, so
// the two operands of an operation are read one after the other.
// Reset empties the stack; memory contents are not cleared. While the
// receiver stalls, the response holds and the next request may already be
// taken and worked up to its response.
module stack_calculator_engine
   import sce_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  sce_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sce_rsp_type rsp_data
);

`include "assert_macros.svh"

   sce_cmd_type  cmd;
   sce_stat_type stat;
   logic         depth_over;

   sce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sce_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .cmd        (cmd),
      .stat       (stat),
      .depth_over (depth_over)
   );

   // One request at a time: block the input right after an acceptance
   `SCE_ASSERT(a_one_at_a_time, clock, reset, (req_valid && !req_stall) |=> req_stall, "request accepted while busy")
   // The stack never grows past its depth
   `SCE_NEVER(a_depth_bound, clock, reset, depth_over, "stack depth exceeds capacity")
   // Requests failed for an empty or short stack return zero
   `SCE_ASSERT(a_fail_zero, clock, reset, (rsp_valid && (rsp_data.status == ST_EMPTY || rsp_data.status == ST_UNDER)) |-> (rsp_data.result_value == 64'd0), "failed request returned a value")

endmodule
